// ===== sv/mbua_pkg.sv =====
// shared types, constants and constant tables of the acceptance evaluator
// no dependencies; every other file imports this package
package mbua_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 32;
  localparam int REG_W     = 31;
  localparam int WID_W     = 32;
  localparam int PROB_W    = 17;
  localparam int CFG_IDX_W = 2;

  // q.32 fixed point constants of the exponential unit
  localparam int                 U_W        = 38;
  localparam int                 K_W        = 5;
  localparam int                 K_MAX      = 25;
  localparam int                 TERMS      = 16;
  localparam logic [U_W-1:0]     LN2_Q32    = 38'h00B17217F8;
  localparam logic [32:0]        ONE_Q32    = 33'h1_0000_0000;
  localparam int                 S1_SHIFT   = 2 * FRAC_BITS;
  localparam int                 T_SHIFT    = 4 * FRAC_BITS - 32;
  localparam logic [38:0]        T_SAT      = 39'h40_0000_0000;
  localparam logic signed [39:0] T_ONE_LIM  = -40'sh01_0000_0000;
  localparam logic signed [39:0] T_ZERO_LIM = 40'sh10_0000_0000;

  // final scaling and division
  localparam int PROB_SHIFT = 14;
  localparam int QBITS      = PROB_W - 1;
  localparam int NUM_W      = 65 - PROB_SHIFT;
  localparam int REM_W      = WID_W + QBITS;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [REG_W-1:0] BETA_RST   = 31'd65536;
  localparam logic [REG_W-1:0] GAMMA_RST  = 31'd0;
  localparam logic [REG_W-1:0] EPS_RST    = 31'd6554;
  localparam logic [REG_W-1:0] BOXLIM_RST = 31'd655360;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BETA   = 2'd0,
    CFG_GAMMA  = 2'd1,
    CFG_EPS    = 2'd2,
    CFG_BOXLIM = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FAULT_NONE   = 2'd0,
    FAULT_RANGE  = 2'd1,
    FAULT_VOLUME = 2'd2,
    FAULT_WIDTH  = 2'd3
  } fault_e;

  typedef enum logic [1:0] {
    RES_CALC = 2'd0,
    RES_ONE  = 2'd1,
    RES_ZERO = 2'd2
  } res_mode_e;

  localparam logic       OP_BOX = 1'b1;
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // classified request handed from the front to the back
  typedef struct packed {
    fault_e            fault;
    logic [WID_W-1:0]  wc;
    logic [WID_W-1:0]  wn;
    logic [31:0]       du_mag;
    logic              neg_du;
    logic [31:0]       dv_mag;
    logic              neg_dv;
    logic [REG_W-1:0]  b1;
    logic [REG_W-1:0]  b2;
  } mbua_item_t;

  typedef struct packed {
    res_mode_e mode;
    fault_e    fault;
  } mbua_tag_t;

  // exact floor(x / n) for 32-bit x: (x * m) >> (32 + l)
  function automatic logic [33:0] recip_mul(input int n);
    logic [33:0] m;
    unique case (n)
      3, 6, 12: m = 34'd5726623062;
      5, 10:    m = 34'd6871947674;
      7, 14:    m = 34'd4908534053;
      9:        m = 34'd7635497416;
      11:       m = 34'd6247225158;
      13:       m = 34'd5286113596;
      15:       m = 34'd4581298450;
      default:  m = 34'h1_0000_0000;
    endcase
    return m;
  endfunction

  function automatic int recip_log(input int n);
    int l;
    unique case (n)
      1:                l = 0;
      2:                l = 1;
      3, 4:             l = 2;
      5, 6, 7, 8:       l = 3;
      default:          l = 4;
    endcase
    return l;
  endfunction

endpackage

// ===== sv/metropolis_bounded_uniform_acceptance.sv =====
// Metropolis-Hastings acceptance probability for bounded uniform moves.
// Takes one move request per cycle and returns one result per request, in order.
// The path runs through the front (check register and queue), the stages that form
// the exponent, the sixteen-term exp series (a multiply and a reciprocal multiply
// per term), the scaling by the window widths and the quotient pipeline (a load
// stage, then one quotient bit per stage). Throughput is one request per clock; a
// stall on the result side while a result is waiting freezes the back pipeline,
// and the front keeps filling its four-entry queue. Configuration registers must
// be written only while no request is in flight.
module metropolis_bounded_uniform_acceptance import mbua_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [REG_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    opcode_i,
  input  logic [1:0]              axis_i,
  input  logic signed [VAL_W-1:0] energy_curr_i,
  input  logic signed [VAL_W-1:0] energy_next_i,
  input  logic signed [VAL_W-1:0] value_curr_i,
  input  logic signed [VAL_W-1:0] value_next_i,
  input  logic signed [VAL_W-1:0] atom_max_i,
  input  logic [REG_W-1:0]        box_x_i,
  input  logic [REG_W-1:0]        box_y_i,
  input  logic [REG_W-1:0]        box_z_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [PROB_W-1:0]       accept_prob_o,
  output logic [1:0]              fault_o
);

  logic [REG_W-1:0] beta_q, gamma_q, eps_q, boxlim_q;
  logic             fr_valid, fr_stall, qu_valid, qu_stall;
  mbua_item_t       fr_item, qu_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q   <= BETA_RST;
      gamma_q  <= GAMMA_RST;
      eps_q    <= EPS_RST;
      boxlim_q <= BOXLIM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BETA:   beta_q   <= cfg_wdata_i;
        CFG_GAMMA:  gamma_q  <= cfg_wdata_i;
        CFG_EPS:    eps_q    <= cfg_wdata_i;
        CFG_BOXLIM: boxlim_q <= cfg_wdata_i;
        default:    beta_q   <= beta_q;
      endcase
    end
  end

  mbua_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .axis_i        (axis_i),
    .energy_curr_i (energy_curr_i),
    .energy_next_i (energy_next_i),
    .value_curr_i  (value_curr_i),
    .value_next_i  (value_next_i),
    .atom_max_i    (atom_max_i),
    .box_x_i       (box_x_i),
    .box_y_i       (box_y_i),
    .box_z_i       (box_z_i),
    .eps_i         (eps_q),
    .box_limit_i   (boxlim_q),
    .out_valid_o   (fr_valid),
    .out_stall_i   (fr_stall),
    .out_item_o    (fr_item)
  );

  mbua_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_stall_o  (fr_stall),
    .in_item_i   (fr_item),
    .out_valid_o (qu_valid),
    .out_stall_i (qu_stall),
    .out_item_o  (qu_item)
  );

  mbua_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (qu_valid),
    .in_stall_o    (qu_stall),
    .in_item_i     (qu_item),
    .beta_i        (beta_q),
    .gamma_i       (gamma_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .accept_prob_o (accept_prob_o),
    .fault_o       (fault_o)
  );

endmodule

// ===== sv/mbua_front.sv =====
// front end: takes a move request, checks it and works out the window widths
// depends on mbua_pkg
module mbua_front import mbua_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    opcode_i,
  input  logic [1:0]              axis_i,
  input  logic signed [VAL_W-1:0] energy_curr_i,
  input  logic signed [VAL_W-1:0] energy_next_i,
  input  logic signed [VAL_W-1:0] value_curr_i,
  input  logic signed [VAL_W-1:0] value_next_i,
  input  logic signed [VAL_W-1:0] atom_max_i,
  input  logic [REG_W-1:0]        box_x_i,
  input  logic [REG_W-1:0]        box_y_i,
  input  logic [REG_W-1:0]        box_z_i,
  input  logic [REG_W-1:0]        eps_i,
  input  logic [REG_W-1:0]        box_limit_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output mbua_item_t              out_item_o
);

  typedef struct packed {
    fault_e           fault;
    logic [33:0]      yc;
    logic [33:0]      yn;
    logic [33:0]      lo;
    logic [33:0]      hi;
    logic [31:0]      du_mag;
    logic             neg_du;
    logic [31:0]      dv_mag;
    logic             neg_dv;
    logic [REG_W-1:0] b1;
    logic [REG_W-1:0] b2;
  } stage_t;

  stage_t           st_d, st_q;
  logic             v_q;
  logic [REG_W-1:0] box_sel;
  logic             op_box;
  logic signed [32:0] du;
  logic signed [33:0] dv;
  logic [32:0]      win_c, win_n;

  // window width of y on (lo, hi); top bit flags out of range
  function automatic logic [32:0] win_f(input logic signed [33:0] y, input logic signed [33:0] lo,
                                        input logic signed [33:0] hi,
                                        input logic signed [33:0] eps);
    logic signed [33:0] aeps;
    logic signed [33:0] beps;
    logic signed [33:0] w;
    logic               bad;
    aeps = lo + eps;
    beps = hi - eps;
    bad  = 1'b0;
    w    = '0;
    priority if (lo < y && y < aeps) begin
      w = y - lo + eps;
    end else if (aeps <= y && y < beps) begin
      w = eps <<< 1;
    end else if (beps <= y && y < hi) begin
      w = hi - y + eps;
    end else begin
      bad = 1'b1;
    end
    return {bad, w[31:0]};
  endfunction

  always_comb begin
    unique case (axis_i)
      AXIS_X:  box_sel = box_x_i;
      AXIS_Y:  box_sel = box_y_i;
      AXIS_Z:  box_sel = box_z_i;
      default: box_sel = '0;
    endcase
    op_box = (opcode_i == OP_BOX);

    priority if (axis_i > AXIS_Z) begin
      st_d.fault = FAULT_RANGE;
    end else if (op_box && (box_x_i == '0 || box_y_i == '0 || box_z_i == '0 ||
                            value_next_i <= 32'sd0)) begin
      st_d.fault = FAULT_VOLUME;
    end else begin
      st_d.fault = FAULT_NONE;
    end

    st_d.lo = op_box ? {{2{atom_max_i[31]}}, atom_max_i} : '0;
    st_d.hi = op_box ? {3'b0, box_limit_i} : {3'b0, box_sel};
    st_d.yc = op_box ? {3'b0, box_sel} : {{2{value_curr_i[31]}}, value_curr_i};
    st_d.yn = {{2{value_next_i[31]}}, value_next_i};

    du = $signed({energy_next_i[31], energy_next_i}) - $signed({energy_curr_i[31], energy_curr_i});
    st_d.neg_du = du[32];
    st_d.du_mag = du[32] ? 32'(-du) : du[31:0];

    dv = $signed(st_d.yn) - $signed(st_d.yc);
    st_d.neg_dv = op_box ? dv[33] : du[32];
    st_d.dv_mag = op_box ? (dv[33] ? 32'(-dv) : dv[31:0]) : '0;

    st_d.b1 = (axis_i == AXIS_X) ? box_y_i : box_x_i;
    st_d.b2 = (axis_i == AXIS_Z) ? box_y_i : box_z_i;
  end

  assign in_stall_o = v_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (!in_stall_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      st_q <= st_d;
    end
  end

  // range and width checks on the registered request
  always_comb begin
    win_c = win_f($signed(st_q.yc), $signed(st_q.lo), $signed(st_q.hi),
                  $signed({3'b0, eps_i}));
    win_n = win_f($signed(st_q.yn), $signed(st_q.lo), $signed(st_q.hi),
                  $signed({3'b0, eps_i}));
    out_item_o.wc     = win_c[31:0];
    out_item_o.wn     = win_n[31:0];
    out_item_o.du_mag = st_q.du_mag;
    out_item_o.neg_du = st_q.neg_du;
    out_item_o.dv_mag = st_q.dv_mag;
    out_item_o.neg_dv = st_q.neg_dv;
    out_item_o.b1     = st_q.b1;
    out_item_o.b2     = st_q.b2;
    priority if (st_q.fault != FAULT_NONE) begin
      out_item_o.fault = st_q.fault;
    end else if (win_c[32] || win_n[32]) begin
      out_item_o.fault = FAULT_RANGE;
    end else if (win_c[31:0] == '0 || win_n[31:0] == '0) begin
      out_item_o.fault = FAULT_WIDTH;
    end else begin
      out_item_o.fault = FAULT_NONE;
    end
  end

  assign out_valid_o = v_q;

endmodule

// ===== sv/mbua_queue.sv =====
// short request queue between front and back
// depends on mbua_pkg
module mbua_queue import mbua_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  mbua_item_t in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output mbua_item_t out_item_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  mbua_item_t           mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [PTR_W:0]       cnt_q, cnt_d;
  logic                 push, pop;

  assign in_stall_o  = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = out_valid_o && !out_stall_i;
  assign out_item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_item_i;
    end
  end

endmodule

// ===== sv/mbua_div.sv =====
// restoring divider, one quotient bit per stage, with saturation at one
// depends on mbua_pkg
module mbua_div import mbua_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               in_valid_i,
  input  mbua_tag_t          in_tag_i,
  input  logic [NUM_W-1:0]   num_i,
  input  logic [WID_W-1:0]   den_i,
  output logic               out_valid_o,
  output logic [PROB_W-1:0]  accept_prob_o,
  output logic [1:0]         fault_o
);

  logic [QBITS:0]     v_q;
  mbua_tag_t          tag_q [QBITS+1];
  logic [REM_W-1:0]   rem_q [QBITS+1];
  logic [WID_W-1:0]   den_q [QBITS+1];
  logic [QBITS-1:0]   quo_q [QBITS+1];
  mbua_tag_t          tag0_d;
  logic               sat;

  always_comb begin
    sat    = {1'b0, num_i} >= (NUM_W+1)'({den_i, {QBITS{1'b0}}});
    tag0_d = in_tag_i;
    if (in_tag_i.mode == RES_CALC && sat) begin
      tag0_d.mode = RES_ONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QBITS-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag0_d;
      rem_q[0] <= num_i[REM_W-1:0];
      den_q[0] <= den_i;
      quo_q[0] <= '0;
    end
  end

  for (genvar s = 1; s <= QBITS; s++) begin : g_bit
    localparam int B = QBITS - s;
    logic [REM_W:0] dsh;
    logic           ge;
    assign dsh = (REM_W+1)'(den_q[s-1]) << B;
    assign ge  = {1'b0, rem_q[s-1]} >= dsh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[s] <= tag_q[s-1];
        den_q[s] <= den_q[s-1];
        rem_q[s] <= ge ? REM_W'({1'b0, rem_q[s-1]} - dsh) : rem_q[s-1];
        quo_q[s] <= quo_q[s-1] | (QBITS'(ge) << B);
      end
    end
  end

  always_comb begin
    unique case (tag_q[QBITS].mode)
      RES_ONE:  accept_prob_o = PROB_W'(1) << QBITS;
      RES_CALC: accept_prob_o = {1'b0, quo_q[QBITS]};
      default:  accept_prob_o = '0;
    endcase
  end

  assign fault_o     = tag_q[QBITS].fault;
  assign out_valid_o = v_q[QBITS];

endmodule

// ===== sv/mbua_back.sv =====
// back end: exponent term, truncated series of exp, window ratio
// depends on mbua_pkg and mbua_div
module mbua_back import mbua_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mbua_item_t         in_item_i,
  input  logic [REG_W-1:0]   beta_i,
  input  logic [REG_W-1:0]   gamma_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PROB_W-1:0]  accept_prob_o,
  output logic [1:0]         fault_o
);

  typedef struct packed {
    mbua_tag_t        tag;
    logic [WID_W-1:0] wc;
    logic [WID_W-1:0] wn;
    logic [K_W-1:0]   k;
  } side_t;

  logic en;
  logic div_valid;

  // front stages: s1 multiply .. s7 range reduction
  logic [7:1]   v_q;
  side_t        sd_q [1:7];
  side_t        sd1_d;
  logic         neg_du_q [1:3];
  logic         neg_dv_q [1:3];
  logic [62:0]  ps1_q, pg_q;
  logic [61:0]  pb_q;
  logic [62:0]  ps1_2_q;
  logic [63:0]  pp00_q;
  logic [61:0]  pp01_q;
  logic [62:0]  pp10_q;
  logic [60:0]  pp11_q;
  logic [127:0] s1_q, s2_q;
  logic [127:0] ssum_q;
  logic         neg_q;
  logic [38:0]  m_q;
  logic [U_W-1:0] u6_q, u7_q;

  logic [127:0] mag, mag_sh;
  logic         sat;
  logic signed [39:0] t;
  logic signed [40:0] u_full;
  side_t        sd6_d;
  side_t        sd7_d;
  logic [K_W-1:0] k_d;

  assign en         = !(div_valid && out_stall_i);
  assign in_stall_o = !en;

  always_comb begin
    sd1_d.tag.fault = in_item_i.fault;
    sd1_d.tag.mode  = (in_item_i.fault != FAULT_NONE) ? RES_ZERO : RES_CALC;
    sd1_d.wc        = in_item_i.wc;
    sd1_d.wn        = in_item_i.wn;
    sd1_d.k         = '0;
  end

  always_comb begin
    mag    = ssum_q[127] ? -ssum_q : ssum_q;
    mag_sh = mag >> T_SHIFT;
    sat    = mag_sh > 128'(T_SAT);
  end

  always_comb begin
    t      = neg_q ? -$signed({1'b0, m_q}) : $signed({1'b0, m_q});
    u_full = 41'(t) + $signed({3'b0, LN2_Q32}) + $signed({3'b0, LN2_Q32});
    sd6_d  = sd_q[5];
    if (sd_q[5].tag.mode == RES_CALC) begin
      if (t <= T_ONE_LIM) begin
        sd6_d.tag.mode = RES_ONE;
      end else if (t >= T_ZERO_LIM) begin
        sd6_d.tag.mode = RES_ZERO;
      end
    end
  end

  // u lies below 26 ln2, so k comes from a bank of constant compares
  always_comb begin
    k_d = '0;
    for (int j = 1; j <= K_MAX; j++) begin
      if (u6_q >= U_W'(j) * LN2_Q32) begin
        k_d = K_W'(j);
      end
    end
  end

  always_comb begin
    sd7_d   = sd_q[6];
    sd7_d.k = k_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[6:1], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // beta*dU, gamma*dV and the cross-section product
      sd_q[1]     <= sd1_d;
      neg_du_q[1] <= in_item_i.neg_du;
      neg_dv_q[1] <= in_item_i.neg_dv;
      ps1_q       <= 63'(beta_i) * 63'(in_item_i.du_mag);
      pg_q        <= 63'(gamma_i) * 63'(in_item_i.dv_mag);
      pb_q        <= 62'(in_item_i.b1) * 62'(in_item_i.b2);
      // partial products of the volume term
      sd_q[2]     <= sd_q[1];
      neg_du_q[2] <= neg_du_q[1];
      neg_dv_q[2] <= neg_dv_q[1];
      ps1_2_q     <= ps1_q;
      pp00_q      <= 64'(pg_q[31:0]) * 64'(pb_q[31:0]);
      pp01_q      <= 62'(pg_q[31:0]) * 62'(pb_q[61:32]);
      pp10_q      <= 63'(pg_q[62:32]) * 63'(pb_q[31:0]);
      pp11_q      <= 61'(pg_q[62:32]) * 61'(pb_q[61:32]);
      sd_q[3]     <= sd_q[2];
      neg_du_q[3] <= neg_du_q[2];
      neg_dv_q[3] <= neg_dv_q[2];
      s1_q        <= 128'(ps1_2_q) << S1_SHIFT;
      s2_q        <= (128'(pp11_q) << 64) + (128'(pp01_q) << 32) + (128'(pp10_q) << 32)
                     + 128'(pp00_q);
      sd_q[4]     <= sd_q[3];
      ssum_q      <= (neg_du_q[3] ? -s1_q : s1_q) + (neg_dv_q[3] ? -s2_q : s2_q);
      sd_q[5]     <= sd_q[4];
      neg_q       <= ssum_q[127];
      m_q         <= sat ? T_SAT : mag_sh[38:0];
      sd_q[6]     <= sd6_d;
      u6_q        <= u_full[U_W-1:0];
      sd_q[7]     <= sd7_d;
      u7_q        <= u6_q;
    end
  end

  // series of exp(-r): stage pair per term, multiply by r then divide by n
  logic [TERMS:1] a_v_q;
  logic [TERMS:0] b_v_q;
  side_t          a_sd_q [1:TERMS];
  side_t          b_sd_q [0:TERMS];
  logic [31:0]    a_x_q [1:TERMS];
  logic [32:0]    a_sum_q [1:TERMS];
  logic [31:0]    a_r_q [1:TERMS];
  logic [32:0]    b_term_q [0:TERMS];
  logic [32:0]    b_sum_q [0:TERMS];
  logic [31:0]    b_r_q [0:TERMS];
  logic [U_W-1:0] kl;

  assign kl = U_W'(sd_q[7].k) * LN2_Q32;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q[0] <= 1'b0;
    end else if (en) begin
      b_v_q[0] <= v_q[7];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_sd_q[0]   <= sd_q[7];
      b_r_q[0]    <= 32'(u7_q - kl);
      b_term_q[0] <= ONE_Q32;
      b_sum_q[0]  <= '0;
    end
  end

  for (genvar n = 1; n <= TERMS; n++) begin : g_term
    localparam logic [33:0] RM = recip_mul(n);
    localparam int          RS = 32 + recip_log(n);
    logic [64:0] prod_a;
    logic [65:0] prod_b;
    assign prod_a = 65'(b_term_q[n-1]) * 65'(b_r_q[n-1]);
    assign prod_b = 66'(a_x_q[n]) * 66'(RM);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        a_v_q[n] <= 1'b0;
        b_v_q[n] <= 1'b0;
      end else if (en) begin
        a_v_q[n] <= b_v_q[n-1];
        b_v_q[n] <= a_v_q[n];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        a_sd_q[n]   <= b_sd_q[n-1];
        a_r_q[n]    <= b_r_q[n-1];
        a_x_q[n]    <= prod_a[63:32];
        // previous term enters the sum: even terms add, odd terms subtract
        a_sum_q[n]  <= ((n - 1) % 2 == 0) ? b_sum_q[n-1] + b_term_q[n-1]
                                           : b_sum_q[n-1] - b_term_q[n-1];
        b_sd_q[n]   <= a_sd_q[n];
        b_r_q[n]    <= a_r_q[n];
        b_sum_q[n]  <= a_sum_q[n];
        b_term_q[n] <= 33'(prod_b >> RS);
      end
    end
  end

  // last term, scaling by the current width, shift by 14+k
  logic [2:0]       t_v_q;
  side_t            e_sd_q, p_sd_q, n_sd_q;
  logic [32:0]      e_sum_q;
  logic [64:0]      prod_q;
  logic [NUM_W-1:0] num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_v_q <= '0;
    end else if (en) begin
      t_v_q <= {t_v_q[1:0], b_v_q[TERMS]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_sd_q  <= b_sd_q[TERMS];
      e_sum_q <= b_sum_q[TERMS] + b_term_q[TERMS];
      p_sd_q  <= e_sd_q;
      prod_q  <= 65'(e_sum_q) * 65'(e_sd_q.wc);
      n_sd_q  <= p_sd_q;
      num_q   <= NUM_W'(prod_q >> (7'(PROB_SHIFT) + 7'(p_sd_q.k)));
    end
  end

  mbua_div u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .in_valid_i    (t_v_q[2]),
    .in_tag_i      (n_sd_q.tag),
    .num_i         (num_q),
    .den_i         (n_sd_q.wn),
    .out_valid_o   (div_valid),
    .accept_prob_o (accept_prob_o),
    .fault_o       (fault_o)
  );

  assign out_valid_o = div_valid;

endmodule

// ===== test/mbua_checker.sv =====
`timescale 1ns / 100ps
// scoreboard of the acceptance evaluator: watches config, request and result ports
// and predicts each result from its own copy of the registers; needs mbua_pkg
module mbua_checker import mbua_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [REG_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic                    opcode_i,
  input  logic [1:0]              axis_i,
  input  logic signed [VAL_W-1:0] energy_curr_i,
  input  logic signed [VAL_W-1:0] energy_next_i,
  input  logic signed [VAL_W-1:0] value_curr_i,
  input  logic signed [VAL_W-1:0] value_next_i,
  input  logic signed [VAL_W-1:0] atom_max_i,
  input  logic [REG_W-1:0]        box_x_i,
  input  logic [REG_W-1:0]        box_y_i,
  input  logic [REG_W-1:0]        box_z_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [PROB_W-1:0]       accept_prob_i,
  input  logic [1:0]              fault_i,
  output int                      mismatch_cnt_o,
  output int                      pending_o
);

  typedef struct packed {
    logic [PROB_W-1:0] prob;
    fault_e            fault;
  } accept_res_t;

  localparam longint LN2 = longint'(LN2_Q32);
  localparam longint ONE = longint'(1) << 32;

  logic [REG_W-1:0] beta_q, gamma_q, eps_q, lim_q;
  accept_res_t      accept_q[$];

  // width of the proposal window around y on (a, b); -1 when out of range
  function automatic longint win_width(longint y, longint a, longint b, longint eps);
    if (a < y && y < a + eps) return y - a + eps;
    if (a + eps <= y && y < b - eps) return 2 * eps;
    if (b - eps <= y && y < b) return b - y + eps;
    return -1;
  endfunction

  function automatic logic [PROB_W-1:0] exp_ratio(longint t, longint wc, longint wn);
    longint      u, k, r;
    logic [63:0] term, sum;
    logic [159:0] x;
    if (t <= -ONE) return PROB_W'(65536);
    if (t >= 16 * ONE) return '0;
    u = t + 2 * LN2;
    k = u / LN2;
    r = u - k * LN2;
    term = 64'(ONE);
    sum  = 64'(ONE);
    for (int n = 1; n <= TERMS; n++) begin
      term = ((term * 64'(r)) >> 32) / 64'(n);
      if (n % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    x = 160'(sum) * 160'(wc);
    x = x >> (14 + k);
    x = x / 160'(wn);
    if (x >= 160'(65536)) return PROB_W'(65536);
    return x[PROB_W-1:0];
  endfunction

  function automatic accept_res_t predict_accept(
      logic op, logic [1:0] axis, longint ec, longint en, longint vc, longint vn,
      longint am, longint bx0, longint bx1, longint bx2);
    accept_res_t  res;
    longint       bx[3];
    longint       yc, lo, hi, wc, wn, d, t;
    logic         neg1, neg2, neg;
    logic [159:0] s1, s2, m;
    bx[0] = bx0; bx[1] = bx1; bx[2] = bx2;
    res.fault = FAULT_NONE;
    res.prob  = '0;
    yc = 0; lo = 0; hi = 0; wc = 0; wn = 0;
    if (axis > AXIS_Z) begin
      res.fault = FAULT_RANGE;
    end else begin
      if (op == OP_BOX) begin
        yc = bx[axis];
        lo = am;
        hi = longint'(lim_q);
        if (bx0 == 0 || bx1 == 0 || bx2 == 0 || vn <= 0) res.fault = FAULT_VOLUME;
      end else begin
        yc = vc;
        hi = bx[axis];
      end
      if (res.fault == FAULT_NONE) begin
        wn = win_width(vn, lo, hi, longint'(eps_q));
        wc = win_width(yc, lo, hi, longint'(eps_q));
        if (wn < 0 || wc < 0) res.fault = FAULT_RANGE;
        else if (wn == 0 || wc == 0) res.fault = FAULT_WIDTH;
      end
    end
    if (res.fault == FAULT_NONE) begin
      neg1 = en < ec;
      d = (en - ec < 0) ? ec - en : en - ec;
      s1 = (160'(beta_q) * 160'(d)) << S1_SHIFT;
      if (op == OP_BOX) begin
        neg2 = vn < yc;
        d = neg2 ? yc - vn : vn - yc;
        s2 = 160'(gamma_q) * 160'(d) * 160'(bx[axis == AXIS_X ? 1 : 0])
             * 160'(bx[axis == AXIS_Z ? 1 : 2]);
      end else begin
        neg2 = neg1;
        s2 = '0;
      end
      if (neg1 == neg2) begin
        s1 = s1 + s2; neg = neg1;
      end else if (s1 >= s2) begin
        s1 = s1 - s2; neg = neg1;
      end else begin
        s1 = s2 - s1; neg = neg2;
      end
      m = s1 >> T_SHIFT;
      if (m > (160'(64) << 32)) m = 160'(64) << 32;
      t = longint'(m[63:0]);
      if (neg) t = -t;
      res.prob = exp_ratio(t, wc, wn);
    end
    return res;
  endfunction

  assign pending_o = accept_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    accept_res_t exp_r;
    if (!rst_ni) begin
      beta_q  <= BETA_RST;
      gamma_q <= GAMMA_RST;
      eps_q   <= EPS_RST;
      lim_q   <= BOXLIM_RST;
      mismatch_cnt_o = 0;
      accept_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_BETA:   beta_q  <= cfg_wdata_i;
          CFG_GAMMA:  gamma_q <= cfg_wdata_i;
          CFG_EPS:    eps_q   <= cfg_wdata_i;
          CFG_BOXLIM: lim_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        accept_q.push_back(predict_accept(opcode_i, axis_i, energy_curr_i, energy_next_i,
            value_curr_i, value_next_i, atom_max_i, box_x_i, box_y_i, box_z_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (accept_q.size() == 0) begin
          mismatch_cnt_o++;
          if (mismatch_cnt_o <= 10)
            $display("unexpected result prob=%0d fault=%0d", accept_prob_i, fault_i);
        end else begin
          exp_r = accept_q.pop_front();
          if (exp_r.prob !== accept_prob_i || exp_r.fault !== fault_i) begin
            mismatch_cnt_o++;
            if (mismatch_cnt_o <= 10)
              $display("result mismatch: expected prob=%0d fault=%0d, got prob=%0d fault=%0d",
                       exp_r.prob, exp_r.fault, accept_prob_i, fault_i);
          end
        end
      end
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// stimulus and verdict for the acceptance evaluator: register phases, directed and
// random move requests under varying idle and stall patterns; needs mbua_pkg and mbua_checker
module testbench;
  import mbua_pkg::*;

  typedef struct {
    logic              op;
    logic [1:0]        axis;
    logic signed [31:0] ec, en, vc, vn, am;
    logic [REG_W-1:0]  bx, by, bz;
  } move_t;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = 1'b0;
  logic [1:0] axis = '0;
  logic signed [VAL_W-1:0] energy_curr = '0, energy_next = '0;
  logic signed [VAL_W-1:0] value_curr = '0, value_next = '0, atom_max = '0;
  logic [REG_W-1:0] box_x = '0, box_y = '0, box_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PROB_W-1:0] accept_prob;
  logic [1:0] fault;
  int mismatch_cnt, pending;
  int idle_pct = 0, stall_pct = 0;
  int cycle_cnt = 0;
  longint cur_lim = 655360, cur_eps = 6554;

  always #10 clk = ~clk;

  metropolis_bounded_uniform_acceptance u_top (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .opcode_i(opcode), .axis_i(axis), .energy_curr_i(energy_curr),
    .energy_next_i(energy_next), .value_curr_i(value_curr), .value_next_i(value_next),
    .atom_max_i(atom_max), .box_x_i(box_x), .box_y_i(box_y), .box_z_i(box_z),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .accept_prob_o(accept_prob),
    .fault_o(fault)
  );

  mbua_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .opcode_i(opcode), .axis_i(axis), .energy_curr_i(energy_curr),
    .energy_next_i(energy_next), .value_curr_i(value_curr), .value_next_i(value_next),
    .atom_max_i(atom_max), .box_x_i(box_x), .box_y_i(box_y), .box_z_i(box_z),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .accept_prob_i(accept_prob),
    .fault_i(fault), .mismatch_cnt_o(mismatch_cnt), .pending_o(pending)
  );

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic longint rand_in(longint lo, longint hi);
    logic [63:0] x;
    if (hi <= lo) return lo;
    x = {$urandom, $urandom};
    return lo + longint'(x % 64'(hi - lo + 1));
  endfunction

  function automatic move_t mk(int op, int ax, longint ec, longint en, longint vc,
                               longint vn, longint am, longint bx, longint by, longint bz);
    move_t m;
    m.op = 1'(op); m.axis = 2'(ax);
    m.ec = 32'(ec); m.en = 32'(en); m.vc = 32'(vc); m.vn = 32'(vn); m.am = 32'(am);
    m.bx = REG_W'(bx); m.by = REG_W'(by); m.bz = REG_W'(bz);
    return m;
  endfunction

  task automatic send_move(move_t m);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    opcode <= m.op; axis <= m.axis; energy_curr <= m.ec; energy_next <= m.en;
    value_curr <= m.vc; value_next <= m.vn; atom_max <= m.am;
    box_x <= m.bx; box_y <= m.by; box_z <= m.bz;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // drains in-flight requests, then writes all four registers back to back
  task automatic set_regs(longint beta, longint gamma, longint eps, longint lim);
    longint vals[4];
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (70) @(negedge clk);
    vals = '{beta, gamma, eps, lim};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= REG_W'(vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    cur_eps = eps;
    cur_lim = lim;
  endtask

  task automatic rand_move(output move_t m);
    longint bl, am, b[3], de, vc;
    int ax;
    if ($urandom_range(99) < 10) begin
      m = mk(int'($urandom_range(1)), int'($urandom_range(3)), $signed($urandom),
             $signed($urandom), $signed($urandom), $signed($urandom), $signed($urandom),
             $urandom, $urandom, $urandom);
      return;
    end
    ax = ($urandom_range(15) == 0) ? 3 : int'($urandom_range(2));
    de = ($urandom_range(7) == 0) ? rand_in(-(64'sd1 << 31), (64'sd1 << 31))
                                  : rand_in(-262144, 262144);
    m.ec = $signed($urandom);
    m.en = 32'(longint'(m.ec) + de);
    m.op = 1'($urandom_range(1));
    m.axis = 2'(ax);
    if (m.op == 1'b0) begin
      bl = (cur_lim > 0) ? cur_lim : 2000000;
      for (int i = 0; i < 3; i++) b[i] = rand_in(1, bl);
      vc = rand_in(0, b[ax % 3] + 1);
      m.vc = 32'(vc);
      m.vn = 32'(($urandom_range(3) == 0) ? rand_in(0, b[ax % 3] + 1)
                                           : vc + rand_in(-2 * cur_eps, 2 * cur_eps));
      m.am = $signed($urandom);
    end else begin
      am = rand_in(-100000, cur_lim / 2);
      for (int i = 0; i < 3; i++) b[i] = rand_in(1, cur_lim);
      b[ax % 3] = rand_in((am + 1 > 1) ? am + 1 : 1, cur_lim - 1);
      m.am = 32'(am);
      m.vn = 32'(($urandom_range(3) == 0) ? b[ax % 3] + rand_in(-cur_eps, cur_eps)
                                           : rand_in(am + 1, cur_lim));
      m.vc = $signed($urandom);
    end
    m.bx = REG_W'(b[0]); m.by = REG_W'(b[1]); m.bz = REG_W'(b[2]);
  endtask

  initial begin
    move_t  m;
    longint ph[8][4];
    int     cnt;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed requests at the reset register values
    send_move(mk(0, AXIS_X, 0, 65536, 100000, 110000, 0, 655360, 655360, 655360));
    send_move(mk(0, AXIS_Y, 65536, 0, 100000, 90000, 0, 655360, 655360, 655360));
    send_move(mk(0, AXIS_Z, 0, 30000, 3000, 9000, 0, 655360, 655360, 655360));
    send_move(mk(0, AXIS_X, 0, 100, 600000, 654000, 0, 655360, 655360, 655360));
    send_move(mk(1, AXIS_X, 0, 1000, 0, 400000, 300000, 500000, 400000, 300000));
    send_move(mk(1, AXIS_Z, 500, 0, 0, 620000, 100, 600000, 400000, 650000));
    send_move(mk(0, 3, 0, 0, 1000, 1000, 0, 655360, 655360, 655360));
    send_move(mk(1, 3, 0, 0, 1000, 1000, 0, 655360, 655360, 655360));
    send_move(mk(1, AXIS_Y, 0, 0, 0, 400000, 0, 0, 400000, 400000));
    send_move(mk(1, AXIS_Y, 0, 0, 0, 0, -10, 400000, 400000, 400000));
    send_move(mk(1, AXIS_X, 0, 0, 0, -5, -10, 400000, 400000, 400000));
    send_move(mk(0, AXIS_X, 0, 0, 0, 1000, 0, 655360, 655360, 655360));
    send_move(mk(0, AXIS_X, 0, 0, 1000, 655360, 0, 655360, 655360, 655360));
    send_move(mk(1, AXIS_X, 0, 0, 0, 655360, 0, 400000, 400000, 400000));
    send_move(mk(0, AXIS_X, -(64'sd1 << 31), (64'sd1 << 31) - 1, 50000, 60000, 0,
                 655360, 655360, 655360));
    send_move(mk(0, AXIS_X, (64'sd1 << 31) - 1, -(64'sd1 << 31), 50000, 60000, 0,
                 655360, 655360, 655360));
    send_move(mk(0, AXIS_Z, -1, -1, -1, -1, -1, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff));
    send_move(mk(1, AXIS_X, 0, 0, 0, 1, -(64'sd1 << 31), 655359, 1, 1));

    ph = '{'{65536, 0, 6554, 655360}, '{65536, 3, 6554, 655360},
           '{0, 0, 1, 655360}, '{32768, 1, 30000, 2000000},
           '{31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff},
           '{0, 0, 0, 655360}, '{1000, 0, 6554, 0}, '{65536, 2, 10000, 1000000}};
    for (int p = 0; p < 8; p++) begin
      set_regs(ph[p][0], ph[p][1], ph[p][2], ph[p][3]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 75; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      if (p == 5) begin
        // zero half window: every in-range width collapses to zero
        send_move(mk(0, AXIS_X, 0, 100, 1000, 2000, 0, 655360, 655360, 655360));
        send_move(mk(1, AXIS_Y, 0, 100, 0, 300000, 100, 400000, 200000, 400000));
      end
      cnt = (p == 5) ? 20 : 115;
      for (int i = 0; i < cnt; i++) begin
        rand_move(m);
        send_move(m);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/mbua_pkg.sv
sv/mbua_front.sv
sv/mbua_queue.sv
sv/mbua_div.sv
sv/mbua_back.sv
sv/metropolis_bounded_uniform_acceptance.sv
test/mbua_checker.sv
test/testbench.sv
